// ===== design/c2dme_pkg.sv =====
`timescale 1ns / 1ps
package c2dme_pkg;

   localparam int CSR_DW  = 7;
   localparam int CSR_AW  = 3;
   localparam int KIND_W  = 4;

   localparam logic [1:0] MODE_SRC = 2'd0;
   localparam logic [1:0] MODE_KER = 2'd1;
   localparam logic [1:0] MODE_RUN = 2'd2;

   localparam logic [CSR_AW-1:0] REG_KIND  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_SROWS = 3'd1;
   localparam logic [CSR_AW-1:0] REG_SCOLS = 3'd2;
   localparam logic [CSR_AW-1:0] REG_KROWS = 3'd3;
   localparam logic [CSR_AW-1:0] REG_KCOLS = 3'd4;

   // low two bits of the kind select the linear form
   localparam logic [1:0] SUB_FULL  = 2'd0;
   localparam logic [1:0] SUB_SAME  = 2'd1;
   localparam logic [1:0] SUB_VALID = 2'd2;
   localparam logic [1:0] SUB_VSAME = 2'd3;

   localparam logic [KIND_W-1:0] KIND_CORR_FIRST = 4'd4;
   localparam logic [KIND_W-1:0] KIND_CORR_LAST  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_CIRC_FULL  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_CIRC_SAME  = 4'd9;

   typedef struct packed {
      logic [1:0]         mode;
      logic [6:0]         row;
      logic [6:0]         col;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic signed [47:0] sum;
      logic               out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic wr_src;
      logic wr_ker;
      logic start;
      logic step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic last_tap;
   } sts_type;

endpackage

// ===== design/c2dme_cfg.sv =====
`timescale 1ns / 1ps
module c2dme_cfg
   import c2dme_pkg::*;
#(
   parameter int MAX_SRC_DIM    = 64,
   parameter int MAX_KERNEL_DIM = 16,
   parameter int SD_W           = $clog2(MAX_SRC_DIM + 1),
   parameter int KD_W           = $clog2(MAX_KERNEL_DIM + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   output logic [KIND_W-1:0] conv_kind,
   output logic [SD_W-1:0]   src_rows,
   output logic [SD_W-1:0]   src_cols,
   output logic [KD_W-1:0]   kernel_rows,
   output logic [KD_W-1:0]   kernel_cols
);

   localparam int SRC_RST = (MAX_SRC_DIM < 64) ? MAX_SRC_DIM : 64;
   localparam int KER_RST = (MAX_KERNEL_DIM < 3) ? MAX_KERNEL_DIM : 3;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SD_W-1:0]   srows_ff, srows_in, scols_ff, scols_in;
   logic [KD_W-1:0]   krows_ff, krows_in, kcols_ff, kcols_in;

   function automatic logic [SD_W-1:0] clamp_src(input logic [CSR_DW-1:0] v);
      logic [SD_W-1:0] r;
      if (v == '0) r = SD_W'(1);
      else if (32'(v) > MAX_SRC_DIM) r = SD_W'(MAX_SRC_DIM);
      else r = SD_W'(v);
      return r;
   endfunction

   function automatic logic [KD_W-1:0] clamp_ker(input logic [CSR_DW-1:0] v);
      logic [KD_W-1:0] r;
      if (v == '0) r = KD_W'(1);
      else if (32'(v) > MAX_KERNEL_DIM) r = KD_W'(MAX_KERNEL_DIM);
      else r = KD_W'(v);
      return r;
   endfunction

   always_comb begin
      kind_in  = kind_ff;
      srows_in = srows_ff;
      scols_in = scols_ff;
      krows_in = krows_ff;
      kcols_in = kcols_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_KIND: begin
               // drop kinds past the last one
               if (csr_wdata <= CSR_DW'(KIND_CIRC_SAME)) kind_in = KIND_W'(csr_wdata);
            end
            REG_SROWS: srows_in = clamp_src(csr_wdata);
            REG_SCOLS: scols_in = clamp_src(csr_wdata);
            REG_KROWS: krows_in = clamp_ker(csr_wdata);
            REG_KCOLS: kcols_in = clamp_ker(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= '0;
         srows_ff <= SD_W'(SRC_RST);
         scols_ff <= SD_W'(SRC_RST);
         krows_ff <= KD_W'(KER_RST);
         kcols_ff <= KD_W'(KER_RST);
      end else begin
         kind_ff  <= kind_in;
         srows_ff <= srows_in;
         scols_ff <= scols_in;
         krows_ff <= krows_in;
         kcols_ff <= kcols_in;
      end
   end

   assign conv_kind   = kind_ff;
   assign src_rows    = srows_ff;
   assign src_cols    = scols_ff;
   assign kernel_rows = krows_ff;
   assign kernel_cols = kcols_ff;

endmodule

// ===== design/c2dme_ctrl.sv =====
`timescale 1ns / 1ps
module c2dme_ctrl
   import c2dme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_mode)
                  MODE_SRC: cmd.wr_src = 1'b1;
                  MODE_KER: cmd.wr_ker = 1'b1;
                  MODE_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = sts.oor ? ST_FINISH : ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.last_tap) state_in = ST_DRAIN1;
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_FINISH;
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/c2dme_dp.sv =====
`timescale 1ns / 1ps
module c2dme_dp
   import c2dme_pkg::*;
#(
   parameter int MAX_SRC_DIM    = 64,
   parameter int MAX_KERNEL_DIM = 16,
   parameter int SD_W           = $clog2(MAX_SRC_DIM + 1),
   parameter int KD_W           = $clog2(MAX_KERNEL_DIM + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [KIND_W-1:0] conv_kind,
   input  logic [SD_W-1:0]   src_rows,
   input  logic [SD_W-1:0]   src_cols,
   input  logic [KD_W-1:0]   kernel_rows,
   input  logic [KD_W-1:0]   kernel_cols,
   output rsp_type           rsp
);

   localparam int IDX_W  = $clog2(MAX_SRC_DIM + MAX_KERNEL_DIM + 128) + 2;
   localparam int SRC_AW = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM * MAX_SRC_DIM) : 1;
   localparam int KER_AW = (MAX_KERNEL_DIM > 1) ?
                           $clog2(MAX_KERNEL_DIM * MAX_KERNEL_DIM) : 1;
   localparam int KI_W   = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
   localparam int SRC_N  = MAX_SRC_DIM * MAX_SRC_DIM;
   localparam int KER_N  = MAX_KERNEL_DIM * MAX_KERNEL_DIM;

   logic signed [15:0] src_mem [SRC_N];
   logic signed [15:0] ker_mem [KER_N];

   logic                    circ, flip, vsame, full_like, valid_like, empty;
   logic [1:0]              sub;
   logic signed [IDX_W-1:0] sr_d, sc_d, kr_d, kc_d, h, w, oh, ow;
   logic signed [IDX_W-1:0] r_s, c_s, row_st0, col_st0, row_st, col_st;
   logic signed [IDX_W-1:0] wrap_h, wrap_w, row_dec, col_dec;
   logic                    wrap_en, in_rng, last_col;

   logic signed [IDX_W-1:0] sr_ff, sc_ff, sc_start_ff;
   logic [KI_W-1:0]         kr_ff, kc_ff;
   logic [KD_W-1:0]         kre, kce;
   logic [SRC_AW-1:0]       src_addr, src_waddr;
   logic [KER_AW-1:0]       ker_addr, ker_waddr;

   logic signed [15:0] src_rd_ff, ker_rd_ff;
   logic               tap_vld_ff, prod_vld_ff, oor_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff;
   rsp_type            rsp_ff;

   // output geometry
   always_comb begin
      circ       = (conv_kind >= KIND_CIRC_FULL);
      flip       = (conv_kind >= KIND_CORR_FIRST) && (conv_kind <= KIND_CORR_LAST);
      sub        = conv_kind[1:0];
      full_like  = circ ? (conv_kind == KIND_CIRC_FULL) : (sub == SUB_FULL);
      valid_like = !circ && ((sub == SUB_VALID) || (sub == SUB_VSAME));
      vsame      = !circ && (sub == SUB_VSAME);
      sr_d = IDX_W'(src_rows);
      sc_d = IDX_W'(src_cols);
      kr_d = IDX_W'(kernel_rows);
      kc_d = IDX_W'(kernel_cols);
      empty = valid_like && ((kr_d > sr_d) || (kc_d > sc_d));
      if (full_like) begin
         h = sr_d + kr_d - IDX_W'(1);
         w = sc_d + kc_d - IDX_W'(1);
      end else if (!circ && (sub == SUB_VALID)) begin
         h = sr_d - kr_d + IDX_W'(1);
         w = sc_d - kc_d + IDX_W'(1);
      end else begin
         h = sr_d;
         w = sc_d;
      end
      if (circ || (sub == SUB_FULL)) begin
         oh = '0;
         ow = '0;
      end else if (sub == SUB_SAME) begin
         oh = kr_d >>> 1;
         ow = kc_d >>> 1;
      end else begin
         oh = kr_d - IDX_W'(1);
         ow = kc_d - IDX_W'(1);
      end
      r_s = IDX_W'(req.row);
      c_s = IDX_W'(req.col);
      sts.oor = empty || (r_s >= h) || (c_s >= w);
      // first source position of the walk; valid-same wraps it once
      row_st0 = r_s + oh;
      col_st0 = c_s + ow;
      row_st  = (vsame && (row_st0 >= sr_d)) ? row_st0 - sr_d : row_st0;
      col_st  = (vsame && (col_st0 >= sc_d)) ? col_st0 - sc_d : col_st0;
      wrap_en = circ || vsame;
      wrap_h  = circ ? h : sr_d;
      wrap_w  = circ ? w : sc_d;
      row_dec = (wrap_en && (sr_ff == '0)) ? wrap_h - IDX_W'(1) : sr_ff - IDX_W'(1);
      col_dec = (wrap_en && (sc_ff == '0)) ? wrap_w - IDX_W'(1) : sc_ff - IDX_W'(1);
      in_rng  = (sr_ff >= 0) && (sr_ff < sr_d) && (sc_ff >= 0) && (sc_ff < sc_d);
      last_col = (KD_W'(kc_ff) == kernel_cols - KD_W'(1));
      sts.last_tap = last_col && (KD_W'(kr_ff) == kernel_rows - KD_W'(1));
      kre = flip ? KD_W'(kernel_rows - KD_W'(1) - KD_W'(kr_ff)) : KD_W'(kr_ff);
      kce = flip ? KD_W'(kernel_cols - KD_W'(1) - KD_W'(kc_ff)) : KD_W'(kc_ff);
      src_addr  = SRC_AW'(sr_ff * MAX_SRC_DIM + sc_ff);
      ker_addr  = KER_AW'(kre * MAX_KERNEL_DIM + kce);
      src_waddr = SRC_AW'(req.row * MAX_SRC_DIM + req.col);
      ker_waddr = KER_AW'(req.row * MAX_KERNEL_DIM + req.col);
   end

   // stores: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.wr_src && (32'(req.row) < MAX_SRC_DIM) && (32'(req.col) < MAX_SRC_DIM))
         src_mem[src_waddr] <= req.value;
      src_rd_ff <= src_mem[src_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_ker && (32'(req.row) < MAX_KERNEL_DIM) &&
          (32'(req.col) < MAX_KERNEL_DIM))
         ker_mem[ker_waddr] <= req.value;
      ker_rd_ff <= ker_mem[ker_addr];
   end

   // tap walk
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sr_ff       <= row_st;
         sc_ff       <= col_st;
         sc_start_ff <= col_st;
         kr_ff       <= '0;
         kc_ff       <= '0;
      end else if (cmd.step) begin
         if (last_col) begin
            kc_ff <= '0;
            kr_ff <= kr_ff + KI_W'(1);
            sc_ff <= sc_start_ff;
            sr_ff <= row_dec;
         end else begin
            kc_ff <= kc_ff + KI_W'(1);
            sc_ff <= col_dec;
         end
      end
   end

   // multiply-accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         tap_vld_ff  <= cmd.step && in_rng;
         prod_vld_ff <= tap_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= src_rd_ff * ker_rd_ff;
      if (cmd.start) begin
         acc_ff <= '0;
         oor_ff <= sts.oor;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + 48'(prod_ff);
      end
      if (cmd.out_load) begin
         rsp_ff.sum          <= oor_ff ? '0 : acc_ff;
         rsp_ff.out_of_range <= oor_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== design/conv2d_multimode_engine_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                Direction  Beat
// request   req_valid, req_ready, req_data       in         load or compute item
// response  rsp_valid, rsp_ready, rsp_data       out        sum and out_of_range
// config    csr_we, csr_addr, csr_wdata          in         register write
//
// A load beat gives no response.
// A compute beat walks every tap, one multiply-accumulate per tap through the source
// and kernel store read ports, then passes the drain states ST_DRAIN1 and ST_DRAIN2.
// A position outside the output skips the tap walk and goes straight to the finish state.
// Reset is synchronous; the stores are not cleared and hold garbage until loaded.
// A stalled response holds in its output register; loads are still taken while idle.
module conv2d_multimode_engine_core
   import c2dme_pkg::*;
#(
   parameter int MAX_SRC_DIM    = 64,
   parameter int MAX_KERNEL_DIM = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int SD_W = $clog2(MAX_SRC_DIM + 1);
   localparam int KD_W = $clog2(MAX_KERNEL_DIM + 1);

   logic [KIND_W-1:0] conv_kind;
   logic [SD_W-1:0]   src_rows, src_cols;
   logic [KD_W-1:0]   kernel_rows, kernel_cols;
   cmd_type           cmd;
   sts_type           sts;

   // configuration registers, saturated on write
   c2dme_cfg #(
      .MAX_SRC_DIM(MAX_SRC_DIM),
      .MAX_KERNEL_DIM(MAX_KERNEL_DIM),
      .SD_W(SD_W),
      .KD_W(KD_W)
   ) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .conv_kind(conv_kind),
      .src_rows(src_rows),
      .src_cols(src_cols),
      .kernel_rows(kernel_rows),
      .kernel_cols(kernel_cols)
   );

   // sequencer: accept, walk taps, drain, hand off to output register
   c2dme_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_data.mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts(sts),
      .cmd(cmd)
   );

   // stores, index walk, multiplier and accumulator
   c2dme_dp #(
      .MAX_SRC_DIM(MAX_SRC_DIM),
      .MAX_KERNEL_DIM(MAX_KERNEL_DIM),
      .SD_W(SD_W),
      .KD_W(KD_W)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req(req_data),
      .cmd(cmd),
      .sts(sts),
      .conv_kind(conv_kind),
      .src_rows(src_rows),
      .src_cols(src_cols),
      .kernel_rows(kernel_rows),
      .kernel_cols(kernel_cols),
      .rsp(rsp_data)
   );

endmodule

// ===== design/c2dme_checker.sv =====
`timescale 1ns / 1ps
module c2dme_checker
   import c2dme_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_RUN |=> !req_ready)
      else $error("request taken while a compute beat is in work");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode != MODE_RUN && !rsp_valid |=> !rsp_valid)
      else $error("load beat produced a response");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.sum == '0)
      else $error("out of range response with nonzero sum");

endmodule

bind conv2d_multimode_engine_core c2dme_checker u_c2dme_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);

// ===== bench/tb_conv2d_multimode_engine_core.sv =====
`timescale 1ns / 1ps
module tb_conv2d_multimode_engine_core;
   import c2dme_pkg::*;

   localparam int SRC_DIM = 64;
   localparam int KER_DIM = 16;
   localparam int FILL_DIM = 20;                // source corner that computes may read
   localparam logic [1:0] MODE_SPARE = 2'd3;    // unused mode, dropped by the block
   localparam logic [CSR_AW-1:0] REG_SPARE = 3'd5;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   conv2d_multimode_engine_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow copy of the engine: both stores and the five registers.
   logic signed [15:0] src_img [SRC_DIM*SRC_DIM];
   logic signed [15:0] ker_img [KER_DIM*KER_DIM];
   logic [3:0] cur_kind = 4'd0;
   int src_h = 64, src_w = 64, ker_h = 3, ker_w = 3;

   req_type beats_to_send [$];
   rsp_type sums_due [$];
   int errors = 0;
   bit no_idle = 1'b0;
   logic hold_go = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Output size and offsets for the current kind and sizes.
   function automatic void out_geom(output int h, output int w, output int oh, output int ow);
      logic [1:0] sub;
      sub = cur_kind[1:0];
      h = 0; w = 0; oh = 0; ow = 0;
      if (cur_kind == KIND_CIRC_FULL) begin
         h = src_h + ker_h - 1; w = src_w + ker_w - 1;
      end else if (cur_kind == KIND_CIRC_SAME) begin
         h = src_h; w = src_w;
      end else if (sub == SUB_FULL) begin
         h = src_h + ker_h - 1; w = src_w + ker_w - 1;
      end else if (sub == SUB_SAME) begin
         h = src_h; w = src_w; oh = ker_h / 2; ow = ker_w / 2;
      end else if (ker_h <= src_h && ker_w <= src_w) begin
         if (sub == SUB_VALID) begin
            h = src_h - ker_h + 1; w = src_w - ker_w + 1;
         end else begin
            h = src_h; w = src_w;
         end
         oh = ker_h - 1; ow = ker_w - 1;
      end
   endfunction

   // Sum of products for one output position.
   function automatic rsp_type conv_point(input int r, input int c);
      int h, w, oh, ow, sr, sc, tr, tc;
      bit circ, flip;
      longint acc;
      rsp_type res;
      circ = cur_kind >= KIND_CIRC_FULL;
      flip = cur_kind >= KIND_CORR_FIRST && cur_kind <= KIND_CORR_LAST;
      acc = 0;
      out_geom(h, w, oh, ow);
      if (h <= 0 || w <= 0 || r >= h || c >= w) begin
         res.sum = '0;
         res.out_of_range = 1'b1;
         return res;
      end
      for (int kr = 0; kr < ker_h; kr++) begin
         for (int kc = 0; kc < ker_w; kc++) begin
            if (circ) begin
               sr = (r - kr) % h; if (sr < 0) sr += h;
               sc = (c - kc) % w; if (sc < 0) sc += w;
               if (sr >= src_h || sc >= src_w) continue;
            end else if (cur_kind[1:0] == SUB_VSAME) begin
               sr = (r + ker_h - 1 - kr) % src_h;
               sc = (c + ker_w - 1 - kc) % src_w;
            end else begin
               sr = r + oh - kr;
               sc = c + ow - kc;
               if (sr < 0 || sr >= src_h || sc < 0 || sc >= src_w) continue;
            end
            tr = flip ? ker_h - 1 - kr : kr;
            tc = flip ? ker_w - 1 - kc : kc;
            acc += longint'(src_img[sr*SRC_DIM + sc]) * longint'(ker_img[tr*KER_DIM + tc]);
         end
      end
      res.sum = acc[47:0];
      res.out_of_range = 1'b0;
      return res;
   endfunction

   // Apply one accepted beat to the shadow state; queue the result it owes.
   function automatic void take_beat(input req_type b);
      case (b.mode)
         MODE_SRC: if (b.row < SRC_DIM && b.col < SRC_DIM) src_img[b.row*SRC_DIM + b.col] = b.value;
         MODE_KER: if (b.row < KER_DIM && b.col < KER_DIM) ker_img[b.row*KER_DIM + b.col] = b.value;
         MODE_RUN: sums_due.push_back(conv_point(b.row, b.col));
         default: ;
      endcase
   endfunction

   function automatic int clamp(input int v, input int hi);
      return v < 1 ? 1 : (v > hi ? hi : v);
   endfunction

   // Driver: offer the next pending beat after a drawn gap; hold payload until taken.
   int send_wait = 0;
   always @(posedge clock) begin
      bit fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) take_beat(req_data);
         if (!req_valid || fire) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
               req_data <= beats_to_send.pop_front();
               req_valid <= 1'b1;
               send_wait = no_idle ? 0 : $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each response beat against the oldest expectation, then
   // draw how long to drop ready. A hold_go pulse forces a long stall.
   int recv_wait = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sums_due.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.sum, 0);
            end else begin
               want = sums_due.pop_front();
               if (rsp_data.sum !== want.sum)
                  report_mismatch("sum", rsp_data.sum, want.sum);
               if (rsp_data.out_of_range !== want.out_of_range)
                  report_mismatch("out_of_range", rsp_data.out_of_range, want.out_of_range);
            end
            recv_wait = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (hold_go) recv_wait = LONG_HOLD;
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   int stuck = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         stuck <= 0;
      end else if (stuck >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   function automatic req_type mk(input logic [1:0] m, input int r, input int c, input int v);
      req_type b;
      b.mode = m; b.row = r[6:0]; b.col = c[6:0]; b.value = v[15:0];
      return b;
   endfunction

   // Drive a register write from the next edge on; the shadow copy is updated at that edge, before the engine takes it.
   task automatic csr_write(input logic [CSR_AW-1:0] a, input int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v[CSR_DW-1:0];
      case (a)
         REG_KIND:  if (v <= 9) cur_kind = v[3:0];
         REG_SROWS: src_h = clamp(v, SRC_DIM);
         REG_SCOLS: src_w = clamp(v, SRC_DIM);
         REG_KROWS: ker_h = clamp(v, KER_DIM);
         REG_KCOLS: ker_w = clamp(v, KER_DIM);
         default: ;
      endcase
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_geom(input int k, input int sr, input int sc, input int kr, input int kc);
      csr_write(REG_KIND, k);
      csr_write(REG_SROWS, sr);
      csr_write(REG_SCOLS, sc);
      csr_write(REG_KROWS, kr);
      csr_write(REG_KCOLS, kc);
      csr_done();
   endtask

   // Wait until every beat went in and every response came back, then let
   // the last load retire before touching the registers.
   task automatic drain();
      while (beats_to_send.size() > 0 || req_valid || sums_due.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Random beat: half computes, most inside or one past the output, rest anywhere;
   // source loads mostly near the origin, some anywhere; a few kernel loads and spares.
   function automatic req_type rand_beat();
      int h, w, oh, ow, pick;
      out_geom(h, w, oh, ow);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (h > 0 && $urandom_range(0, 3) != 0)
            return mk(MODE_RUN, $urandom_range(0, h), $urandom_range(0, w), $urandom);
         return mk(MODE_RUN, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end
      if (pick < 85) begin
         if ($urandom_range(0, 3) == 0)
            return mk(MODE_SRC, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
         return mk(MODE_SRC, $urandom_range(0, 11), $urandom_range(0, 11), $urandom);
      end
      if (pick < 95)
         return mk(MODE_KER, $urandom_range(0, 20), $urandom_range(0, 20), $urandom);
      return mk(MODE_SPARE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
   endfunction

   initial begin
      int k, sr, sc, kr, kc, n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Fill the source corner that computes reach, the far corner and the
      // whole kernel, so that no compute ever reads an unwritten entry.
      @(negedge clock);
      no_idle = 1'b1;
      for (int i = 0; i < FILL_DIM*FILL_DIM; i++)
         beats_to_send.push_back(mk(MODE_SRC, i / FILL_DIM, i % FILL_DIM, $urandom));
      beats_to_send.push_back(mk(MODE_SRC, SRC_DIM - 1, SRC_DIM - 1, $urandom));
      for (int i = 0; i < KER_DIM*KER_DIM; i++)
         beats_to_send.push_back(mk(MODE_KER, i / KER_DIM, i % KER_DIM, $urandom));
      drain();
      no_idle = 1'b0;

      // Directed: extreme values over a full 3x3 window at reset settings,
      // output corners, just-outside positions, loads past the stores, spare mode.
      @(negedge clock);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            beats_to_send.push_back(mk(MODE_SRC, i, j, -32768));
            beats_to_send.push_back(mk(MODE_KER, i, j, -32768));
         end
      end
      beats_to_send.push_back(mk(MODE_RUN, 2, 2, 0));
      beats_to_send.push_back(mk(MODE_RUN, 0, 0, 0));
      beats_to_send.push_back(mk(MODE_RUN, 65, 65, 0));
      beats_to_send.push_back(mk(MODE_RUN, 66, 0, 0));
      beats_to_send.push_back(mk(MODE_RUN, 127, 127, 0));
      beats_to_send.push_back(mk(MODE_SRC, 64, 127, 32767));
      beats_to_send.push_back(mk(MODE_KER, 16, 3, 32767));
      beats_to_send.push_back(mk(MODE_SPARE, 127, 127, -1));
      beats_to_send.push_back(mk(MODE_SRC, 63, 63, 32767));
      beats_to_send.push_back(mk(MODE_RUN, 65, 65, 0));
      drain();

      // Ignored kind, sizes saturated at both ends and the spare indices; then computes at their edges.
      csr_write(REG_KIND, 12);
      csr_write(REG_SROWS, 0);
      csr_write(REG_SCOLS, 127);
      csr_write(REG_KROWS, 127);
      csr_write(REG_KCOLS, 0);
      for (int a = REG_SPARE; a < 8; a++) csr_write(a[CSR_AW-1:0], 127);
      csr_done();
      @(negedge clock);
      beats_to_send.push_back(mk(MODE_RUN, 0, 0, 0));
      beats_to_send.push_back(mk(MODE_RUN, 15, 15, 0));
      beats_to_send.push_back(mk(MODE_RUN, 16, 15, 0));
      beats_to_send.push_back(mk(MODE_RUN, 78, 63, 0));
      drain();

      // Random phases, one per kind first, then random kinds.
      for (int p = 0; p < 14; p++) begin
         k = p < 10 ? p : $urandom_range(0, 9);
         n = 57;
         if (p == 3) begin
            sr = FILL_DIM; sc = FILL_DIM; kr = 16; kc = 16; n = 20;
         end else if (p == 6) begin
            sr = 2; sc = $urandom_range(1, 8); kr = 5; kc = $urandom_range(1, 4);
         end else if (p == 12) begin
            sr = 1; sc = 1; kr = 1; kc = 1;
         end else begin
            sr = $urandom_range(1, 10); sc = $urandom_range(1, 10);
            kr = $urandom_range(1, 6); kc = $urandom_range(1, 6);
         end
         set_geom(k, sr, sc, kr, kc);
         no_idle = (p % 4 == 1);
         @(negedge clock);
         for (int i = 0; i < n; i++) beats_to_send.push_back(rand_beat());
         if (p == 0) begin
            // Stall the response side long enough for the input to back up.
            repeat (40) @(posedge clock);
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (errors == 0 && sums_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
